// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define JBT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tokenizer assertion failed");

// property checked at every edge, reset included
`define JBT_ASSERT_NORST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tokenizer reset assertion failed");

`endif

// ===== hdl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// shared types, sizes and helpers of the json byte tokenizer
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int LEN_BITS    = 16;
  localparam int OUT_LEN_BITS = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

  typedef logic [LEN_BITS-1:0] len_t;

  typedef enum logic [3:0] {
    K_LBRACE   = 4'd0,
    K_RBRACE   = 4'd1,
    K_COLON    = 4'd2,
    K_COMMA    = 4'd3,
    K_LBRACKET = 4'd4,
    K_RBRACKET = 4'd5,
    K_STRING   = 4'd6,
    K_NUMBER   = 4'd7,
    K_BOOL     = 4'd8,
    K_NULL     = 4'd9,
    K_QERR     = 4'd10,
    K_UNKNOWN  = 4'd11
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [OUT_LEN_BITS-1:0] length;
    logic                    ok;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic not_empty;
    logic room2;
  } fifo_status_t;

  function automatic logic [OUT_LEN_BITS-1:0] len_field(input len_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'((1 << OUT_LEN_BITS) - 1)) ? '1 : w[OUT_LEN_BITS-1:0];
  endfunction

  function automatic len_t len_sat_inc(input len_t v);
    return (v == '1) ? v : len_t'(v + 1'b1);
  endfunction

endpackage

// ===== hdl/jbt_channel_if.sv =====
// ----------------------------------------------------------------------------
// jbt channel interfaces
// byte input channel and token result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface jbt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, byte_in, end_of_input, input ready);
  modport sink (input valid, byte_in, end_of_input, output ready);
endinterface

interface jbt_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_length;
  logic        lexical_ok;
  logic        last;

  modport source (output valid, token_kind, token_length, lexical_ok, last, input ready);
  modport sink (input valid, token_kind, token_length, lexical_ok, last, output ready);
endinterface

// ===== hdl/jbt_result_fifo.sv =====
// ----------------------------------------------------------------------------
// jbt_result_fifo
// small result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module jbt_result_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                push_cnt,
  input  jbt_pkg::result_t [1:0]    push_data,
  input  logic                      pop,
  output jbt_pkg::result_t          head,
  output jbt_pkg::fifo_status_t     status
);
  import jbt_pkg::*;

  result_t             mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic [PTR_BITS-1:0] wr_ptr1;
  logic                do_pop;

  assign wr_ptr1 = PTR_BITS'(wr_ptr + 1'b1);
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_data[0];
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_BITS'(wr_ptr + push_cnt);
      if (do_pop) begin
        rd_ptr <= PTR_BITS'(rd_ptr + 1'b1);
      end
      count <= CNT_BITS'(count + push_cnt - CNT_BITS'(do_pop));
    end
  end

  assign head             = mem[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.room2     = (count <= CNT_BITS'(FIFO_DEPTH - 2));

endmodule

// ===== hdl/json_byte_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer_unit
// json lexer: one text byte per transaction in, one token record per
// transaction out
// ----------------------------------------------------------------------------
// usage
//   bytes  : byte_in with end_of_input on the final byte of a document
//   tokens : kind, length, lexical_ok and last; last marks the final record
//            caused by one input byte (a byte causes zero, one or two)
// timing
//   a byte is taken into the input register, scanned in the next cycle and
//   its records are written to a four-entry result queue once the queue has
//   room for two more; the first record is then offered from the queue head
//   and is taken while tokens.ready is high
//   one byte per cycle is sustained while the queue has room; the scan is a
//   single registered pass, the rate is set by the queue draining one record
//   per cycle, and bytes causing two records stall the input once three wait
// stall
//   while tokens.ready is low the head record holds and up to four records
//   wait; bytes keep flowing until the queue has no room for two more
// reset
//   rst clears the input register, the queue and the scanner state; the
//   first byte after reset starts a fresh document
// ----------------------------------------------------------------------------
module json_byte_tokenizer_unit (
  input logic        clk,
  input logic        rst,
  jbt_byte_if.sink   bytes,
  jbt_token_if.source tokens
);
  import jbt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_WORD = 3'd1,
    M_DSTR = 3'd2,
    M_DESC = 3'd3,
    M_SQUO = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    N_START = 4'd0,
    N_SIGN  = 4'd1,
    N_ZERO  = 4'd2,
    N_INT   = 4'd3,
    N_FRAC  = 4'd4,
    N_DOT   = 4'd5,
    N_EXP   = 4'd6,
    N_ESIGN = 4'd7,
    N_EDIG  = 4'd8,
    N_DEAD  = 4'd9
  } num_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic num_t num_next(input num_t s, input logic [7:0] c);
    logic d;
    logic e;
    logic sg;
    num_t r;
    d  = is_digit(c);
    e  = (c == "e") || (c == "E");
    sg = (c == "+") || (c == "-");
    r  = N_DEAD;
    unique case (s)
      N_START, N_SIGN: begin
        if (s == N_START && sg) r = N_SIGN;
        else if (c == "0") r = N_ZERO;
        else if (d) r = N_INT;
        else if (c == ".") r = N_DOT;
      end
      N_ZERO: begin
        if (c == ".") r = N_DOT;
        else if (e) r = N_EXP;
      end
      N_INT: begin
        if (d) r = N_INT;
        else if (c == ".") r = N_FRAC;
        else if (e) r = N_EXP;
      end
      N_FRAC: begin
        if (d) r = N_FRAC;
        else if (e) r = N_EXP;
      end
      N_DOT: if (d) r = N_FRAC;
      N_EXP: begin
        if (sg) r = N_ESIGN;
        else if (d) r = N_EDIG;
      end
      N_ESIGN, N_EDIG: if (d) r = N_EDIG;
      default: r = N_DEAD;
    endcase
    return r;
  endfunction

  // bit 0 true, bit 1 false, bit 2 null
  function automatic logic [2:0] kw_hit(input len_t pos, input logic [7:0] c);
    logic [2:0] m;
    m = 3'b000;
    if (pos <= len_t'(4)) begin
      unique case (pos[2:0])
        3'd0: m = {c == "n", c == "f", c == "t"};
        3'd1: m = {c == "u", c == "a", c == "r"};
        3'd2: m = {c == "l", c == "l", c == "u"};
        3'd3: m = {c == "l", c == "s", c == "e"};
        3'd4: m = {1'b0, c == "e", 1'b0};
        default: m = 3'b000;
      endcase
    end
    return m;
  endfunction

  function automatic kind_t word_kind(input logic [2:0] kw, input len_t n, input num_t s);
    kind_t k;
    if ((kw[0] && n == len_t'(4)) || (kw[1] && n == len_t'(5))) k = K_BOOL;
    else if (s == N_ZERO || s == N_INT || s == N_FRAC || s == N_EDIG) k = K_NUMBER;
    else if (kw[2] && n == len_t'(4)) k = K_NULL;
    else k = K_UNKNOWN;
    return k;
  endfunction

  function automatic logic is_err(input kind_t k);
    return k == K_UNKNOWN || k == K_QERR;
  endfunction

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eoi;

  // scanner state
  mode_t      mode;
  len_t       len;
  num_t       num;
  logic [2:0] kw;
  logic       err;

  mode_t      mode_next;
  len_t       len_next;
  num_t       num_next_s;
  logic [2:0] kw_next;
  logic       err_next;

  result_t [1:0] em;
  logic [1:0]    em_cnt;
  logic          sk_valid;
  kind_t         sk_kind;
  logic          fire;
  logic          pop;

  result_t      head;
  fifo_status_t fstat;

  assign fire        = s1_valid && fstat.room2;
  assign bytes.ready = !s1_valid || fire;
  assign pop         = tokens.ready;

  always_comb begin
    sk_valid = 1'b1;
    sk_kind  = K_LBRACE;
    unique case (s1_byte)
      "{": sk_kind = K_LBRACE;
      "}": sk_kind = K_RBRACE;
      ":": sk_kind = K_COLON;
      ",": sk_kind = K_COMMA;
      "[": sk_kind = K_LBRACKET;
      "]": sk_kind = K_RBRACKET;
      default: sk_valid = 1'b0;
    endcase
  end

  always_comb begin
    mode_next  = mode;
    len_next   = len;
    num_next_s = num;
    kw_next    = kw;
    err_next   = err;
    em         = '0;
    em_cnt     = 2'd0;

    unique case (mode)
      M_WORD: begin
        if (is_ws(s1_byte) || s1_byte == "}" || s1_byte == "]" || s1_byte == ",") begin
          em[em_cnt[0]].kind   = word_kind(kw, len, num);
          em[em_cnt[0]].length = len_field(len);
          err_next             = err_next | is_err(em[em_cnt[0]].kind);
          em[em_cnt[0]].ok     = !err_next;
          em_cnt               = 2'(em_cnt + 1'b1);
          mode_next            = M_IDLE;
          if (sk_valid) begin
            em[em_cnt[0]].kind   = sk_kind;
            em[em_cnt[0]].length = OUT_LEN_BITS'(1);
            em[em_cnt[0]].ok     = !err_next;
            em_cnt               = 2'(em_cnt + 1'b1);
          end
        end else begin
          kw_next    = kw & kw_hit(len, s1_byte);
          num_next_s = num_next(num, s1_byte);
          len_next   = len_sat_inc(len);
        end
      end
      M_DSTR, M_DESC: begin
        if (s1_byte == 8'h0a) begin
          em[0].kind   = K_UNKNOWN;
          em[0].length = len_field(len);
          err_next     = 1'b1;
          em[0].ok     = 1'b0;
          em_cnt       = 2'd1;
          mode_next    = M_IDLE;
        end else begin
          len_next = len_sat_inc(len);
          if (mode == M_DESC) begin
            mode_next = M_DSTR;
          end else if (s1_byte == "\\") begin
            mode_next = M_DESC;
          end else if (s1_byte == "\"") begin
            em[0].kind   = K_STRING;
            em[0].length = len_field(len_next);
            em[0].ok     = !err;
            em_cnt       = 2'd1;
            mode_next    = M_IDLE;
          end
        end
      end
      M_SQUO: begin
        if (s1_byte == 8'h0a || s1_byte == "'") begin
          if (s1_byte == "'") len_next = len_sat_inc(len);
          em[0].kind   = K_QERR;
          em[0].length = len_field(len_next);
          err_next     = 1'b1;
          em[0].ok     = 1'b0;
          em_cnt       = 2'd1;
          mode_next    = M_IDLE;
        end else begin
          len_next = len_sat_inc(len);
        end
      end
      default: begin
        mode_next = M_IDLE;
        priority if (is_ws(s1_byte)) begin
        end else if (s1_byte == "\"") begin
          len_next  = len_t'(1);
          mode_next = M_DSTR;
        end else if (s1_byte == "'") begin
          len_next  = len_t'(1);
          mode_next = M_SQUO;
        end else if (sk_valid) begin
          em[0].kind   = sk_kind;
          em[0].length = OUT_LEN_BITS'(1);
          em[0].ok     = !err;
          em_cnt       = 2'd1;
        end else begin
          kw_next    = kw_hit(len_t'(0), s1_byte);
          num_next_s = num_next(N_START, s1_byte);
          len_next   = len_t'(1);
          mode_next  = M_WORD;
        end
      end
    endcase

    if (s1_eoi) begin
      if (mode_next != M_IDLE) begin
        unique case (mode_next)
          M_WORD:         em[em_cnt[0]].kind = word_kind(kw_next, len_next, num_next_s);
          M_DSTR, M_DESC: em[em_cnt[0]].kind = K_UNKNOWN;
          default:        em[em_cnt[0]].kind = K_QERR;
        endcase
        em[em_cnt[0]].length = len_field(len_next);
        em[em_cnt[0]].ok     = !(err_next | is_err(em[em_cnt[0]].kind));
        em_cnt               = 2'(em_cnt + 1'b1);
      end
      mode_next = M_IDLE;
      err_next  = 1'b0;
    end

    if (em_cnt == 2'd1) em[0].last = 1'b1;
    if (em_cnt == 2'd2) em[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.byte_in;
      s1_eoi  <= bytes.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      mode     <= M_IDLE;
      len      <= '0;
      num      <= N_START;
      kw       <= 3'b111;
      err      <= 1'b0;
    end else begin
      if (bytes.ready) begin
        s1_valid <= bytes.valid;
      end
      if (fire) begin
        mode <= mode_next;
        len  <= len_next;
        num  <= num_next_s;
        kw   <= kw_next;
        err  <= err_next;
      end
    end
  end

  jbt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (fire ? em_cnt : 2'd0),
    .push_data (em),
    .pop       (pop),
    .head      (head),
    .status    (fstat)
  );

  assign tokens.valid        = fstat.not_empty;
  assign tokens.token_kind   = head.kind;
  assign tokens.token_length = head.length;
  assign tokens.lexical_ok   = head.ok;
  assign tokens.last         = head.last;

endmodule

// ===== hdl/jbt_checker.sv =====
// ----------------------------------------------------------------------------
// jbt_checker
// port level checks of the json byte tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [15:0] out_length,
  input logic        out_ok,
  input logic        out_last
);
  import jbt_pkg::*;

  // queue is empty right after reset
  `JBT_ASSERT_NORST(a_reset_empty, rst |=> !out_valid)

  // stalled transaction keeps its record
  `JBT_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable({out_kind, out_length, out_ok, out_last}))

  // an error token always clears lexical_ok
  `JBT_ASSERT(a_err_not_ok, out_valid && (out_kind == K_UNKNOWN || out_kind == K_QERR) |-> !out_ok)

  // structural tokens are one character long
  `JBT_ASSERT(a_struct_len, out_valid && out_kind <= K_RBRACKET |-> out_length == 16'd1)

  // a record appearing on an empty output follows an accepted byte through the input register and the queue
  `JBT_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2))

endmodule

bind json_byte_tokenizer_unit jbt_checker u_jbt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (bytes.valid),
  .in_ready   (bytes.ready),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_kind   (tokens.token_kind),
  .out_length (tokens.token_length),
  .out_ok     (tokens.lexical_ok),
  .out_last   (tokens.last)
);
